>>> rtl/utf8d_pkg.sv
// Shared types and constants for the UTF-8 byte stream decoder.
package utf8d_pkg;

   localparam int ByteW = 8;
   localparam int CodeW = 31;
   localparam int LenW  = 3;
   localparam int CntW  = 3;
   localparam int StatW = 2;

   // Result status codes.
   typedef enum logic [StatW-1:0] {
      ST_OK        = 2'd0,
      ST_INVALID   = 2'd1,
      ST_TRUNCATED = 2'd2
   } status_type;

   typedef struct packed {
      logic [ByteW-1:0] in_byte;
      logic             last_byte;
   } req_type;

   typedef struct packed {
      logic [CodeW-1:0] code_point;
      logic [LenW-1:0]  seq_len;
      status_type       status;
   } rsp_type;

endpackage

>>> rtl/utf8d_if.sv
// Valid/ready channel interfaces for the decoder's byte input and result output.
interface utf8d_req_if;
   logic                        valid;
   logic                        ready;
   logic [utf8d_pkg::ByteW-1:0] in_byte;
   logic                        last_byte;

   modport source (output valid, output in_byte, output last_byte, input ready);
   modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

interface utf8d_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [utf8d_pkg::CodeW-1:0] code_point;
   logic [utf8d_pkg::LenW-1:0]  seq_len;
   logic [utf8d_pkg::StatW-1:0] status;

   modport source (output valid, output code_point, output seq_len, output status,
                   input ready);
   modport sink (input valid, input code_point, input seq_len, input status,
                 output ready);
endinterface

>>> rtl/utf8d_in_reg.sv
// Input register stage that captures one byte beat per cycle while it is empty or its beat advances.
module utf8d_in_reg (
   input  logic               clock,
   input  logic               reset,
   utf8d_req_if.sink          req_chan,
   input  logic               advance,
   output logic               stage_valid,
   output utf8d_pkg::req_type stage_req
);
   import utf8d_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;
   logic    take;

   // The stage frees up in the same cycle its content moves on.
   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;
   assign valid_in       = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         data_ff.in_byte   <= req_chan.in_byte;
         data_ff.last_byte <= req_chan.last_byte;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_req   = data_ff;

endmodule

>>> rtl/utf8d_decode.sv
// Decode step: sequence state registers and the per-byte update and result logic.
module utf8d_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  utf8d_pkg::req_type step_req,
   output logic               res_valid,
   output utf8d_pkg::rsp_type res
);
   import utf8d_pkg::*;

   localparam logic [LenW-1:0] LenIdle = 3'd1;

   logic [CntW-1:0]  pending_count_ff, pending_count_in;
   logic [CodeW-1:0] partial_code_ff, partial_code_in;
   logic [LenW-1:0]  current_len_ff, current_len_in;
   logic [ByteW-1:0] b;
   logic [CntW-1:0]  pend_dec;
   logic [CodeW-1:0] cont_bits;

   assign b        = step_req.in_byte;
   assign pend_dec = pending_count_ff - 3'd1;

   // Place the six payload bits of a continuation byte by the count left after it.
   always_comb begin
      case (pend_dec)
         3'd0:    cont_bits = {25'b0, b[5:0]};
         3'd1:    cont_bits = {19'b0, b[5:0], 6'b0};
         3'd2:    cont_bits = {13'b0, b[5:0], 12'b0};
         3'd3:    cont_bits = {7'b0, b[5:0], 18'b0};
         default: cont_bits = {1'b0, b[5:0], 24'b0};
      endcase
   end

   always_comb begin
      pending_count_in = pending_count_ff;
      partial_code_in  = partial_code_ff;
      current_len_in   = current_len_ff;
      res_valid        = 1'b0;
      res              = '0;
      case (b) inside
         [8'h00:8'h7F]: begin
            pending_count_in = '0;
            partial_code_in  = '0;
            current_len_in   = LenIdle;
            res_valid        = 1'b1;
            res.code_point   = {23'b0, b};
            res.seq_len      = 3'd1;
            res.status       = ST_OK;
         end
         [8'h80:8'hBF]: begin
            if (pending_count_ff == '0) begin
               res_valid  = 1'b1;
               res.status = ST_INVALID;
               current_len_in = LenIdle;
               partial_code_in = '0;
            end else if (pend_dec == '0) begin
               res_valid        = 1'b1;
               res.code_point   = partial_code_ff | cont_bits;
               res.seq_len      = current_len_ff;
               res.status       = ST_OK;
               pending_count_in = '0;
               partial_code_in  = '0;
               current_len_in   = LenIdle;
            end else begin
               pending_count_in = pend_dec;
               partial_code_in  = partial_code_ff | cont_bits;
            end
         end
         [8'hC0:8'hDF]: begin
            pending_count_in = 3'd1;
            current_len_in   = 3'd2;
            partial_code_in  = {20'b0, b[4:0], 6'b0};
         end
         [8'hE0:8'hEF]: begin
            pending_count_in = 3'd2;
            current_len_in   = 3'd3;
            partial_code_in  = {15'b0, b[3:0], 12'b0};
         end
         [8'hF0:8'hF7]: begin
            pending_count_in = 3'd3;
            current_len_in   = 3'd4;
            partial_code_in  = {10'b0, b[2:0], 18'b0};
         end
         [8'hF8:8'hFB]: begin
            pending_count_in = 3'd4;
            current_len_in   = 3'd5;
            partial_code_in  = {5'b0, b[1:0], 24'b0};
         end
         [8'hFC:8'hFD]: begin
            pending_count_in = 3'd5;
            current_len_in   = 3'd6;
            partial_code_in  = {b[0], 30'b0};
         end
         default: begin
            pending_count_in = '0;
            partial_code_in  = '0;
            current_len_in   = LenIdle;
            res_valid        = 1'b1;
            res.status       = ST_INVALID;
         end
      endcase

      // The last byte of a buffer closes any open sequence.
      if (step_req.last_byte) begin
         if (!res_valid && pending_count_in != '0) begin
            res_valid  = 1'b1;
            res        = '0;
            res.status = ST_TRUNCATED;
         end
         pending_count_in = '0;
         partial_code_in  = '0;
         current_len_in   = LenIdle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_count_ff <= '0;
         partial_code_ff  <= '0;
         current_len_ff   <= LenIdle;
      end else if (step_en) begin
         pending_count_ff <= pending_count_in;
         partial_code_ff  <= partial_code_in;
         current_len_ff   <= current_len_in;
      end
   end

   a_pending_below_len: assert property (@(posedge clock) disable iff (reset)
      pending_count_ff < current_len_ff)
      else $error("pending count not below sequence length");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      step_en && step_req.last_byte |=> pending_count_ff == '0 && current_len_ff == LenIdle)
      else $error("state not cleared after last byte");

   a_multi_ok_needs_one_left: assert property (@(posedge clock) disable iff (reset)
      step_en && res_valid && res.status == ST_OK && res.seq_len != 3'd1
      |-> pending_count_ff == 3'd1)
      else $error("multi-byte character emitted with wrong pending count");

   a_error_zero_payload: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.status != ST_OK |-> res.code_point == '0 && res.seq_len == '0)
      else $error("error result carries payload");

endmodule

>>> rtl/utf8d_out_reg.sv
// Result register that holds one result beat until the sink takes it.
module utf8d_out_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  utf8d_pkg::rsp_type load_rsp,
   utf8d_rsp_if.source        rsp_chan,
   output logic               out_free
);
   import utf8d_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign out_free = !valid_ff || rsp_chan.ready;
   assign valid_in = load || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= load_rsp;
      end
   end

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.code_point = data_ff.code_point;
   assign rsp_chan.seq_len    = data_ff.seq_len;
   assign rsp_chan.status     = data_ff.status;

endmodule

>>> rtl/utf8_byte_stream_decoder.sv
// A byte beat is registered in the input stage, and its result in the output register, before it shows on rsp_chan.
// Throughput: one byte per cycle unless the result sink stalls; the decode state loop is a single register update.
// A byte that completes nothing (lead or inner continuation) yields no result beat unless marked last (truncated).
// A stalled result sink holds the output register and, through it, the input stage.
// Reset is synchronous and active high: both stages empty, no sequence open.
// Top level of the UTF-8 byte stream decoder.
module utf8_byte_stream_decoder (
   input logic         clock,
   input logic         reset,
   utf8d_req_if.sink   req_chan,
   utf8d_rsp_if.source rsp_chan
);
   import utf8d_pkg::*;

   logic    stage_valid;
   req_type stage_req;
   logic    res_valid;
   rsp_type res;
   logic    out_free;
   logic    advance;

   // The byte in the input stage is decoded in the cycle it leaves. It may leave
   // whenever the output register is free, even if it yields no result, so that
   // the state update and any result are always committed together.
   assign advance = stage_valid && out_free;

   utf8d_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_req   (stage_req)
   );

   // The decode step keeps the open sequence: bytes still expected, the code point
   // gathered so far and the sequence length. A new lead, ASCII or invalid byte abandons it.
   utf8d_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .step_req  (stage_req),
      .res_valid (res_valid),
      .res       (res)
   );

   // Only steps that produce a result load the output register.
   utf8d_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && res_valid),
      .load_rsp (res),
      .rsp_chan (rsp_chan),
      .out_free (out_free)
   );

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the UTF-8 byte stream decoder: directed and random byte beats.
module tb_top;
   import utf8d_pkg::*;

   // Byte classes of lenient six-byte UTF-8. Each lead class starts at the constant below.
   localparam logic [7:0] ContMin   = 8'h80;
   localparam logic [7:0] Lead2Min  = 8'hC0;
   localparam logic [7:0] Lead3Min  = 8'hE0;
   localparam logic [7:0] Lead4Min  = 8'hF0;
   localparam logic [7:0] Lead5Min  = 8'hF8;
   localparam logic [7:0] Lead6Min  = 8'hFC;
   localparam logic [7:0] BadMin    = 8'hFE;
   localparam logic [7:0] ContMask  = 8'h3F;
   localparam logic [7:0] Lead2Mask = 8'h1F;
   localparam logic [7:0] Lead3Mask = 8'h0F;
   localparam logic [7:0] Lead4Mask = 8'h07;
   localparam logic [7:0] Lead5Mask = 8'h03;
   localparam logic [7:0] Lead6Mask = 8'h01;

   // The watchdog fires after this many cycles in which no beat moves on either channel.
   // The longest legal quiet stretch is the receiver hold-off below plus a few stall bursts.
   localparam int IdleLimit   = 2000;
   localparam int HoldCycles  = 300;
   localparam int MaxReports  = 10;
   localparam int TailCycles  = 4;

   logic clock = 1'b0;
   logic reset;

   always #5 clock = ~clock;

   utf8d_req_if req_chan ();
   utf8d_rsp_if rsp_chan ();

   utf8_byte_stream_decoder uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Results predicted for accepted byte beats, oldest first.
   rsp_type expected_results[$];

   // Decoder state as the predictor tracks it.
   logic [2:0]  open_remaining;
   logic [30:0] gathered_code;
   logic [2:0]  open_len;

   int  fail_count;
   int  bytes_sent;
   int  quiet_cycles;
   int  hold_off_cycles;
   bit  req_idle_en;
   bit  rsp_stall_en;

   // ---------------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------------

   // Forget any open sequence; a lone byte has length one.
   function automatic void clear_decode();
      open_remaining = '0;
      gathered_code  = '0;
      open_len       = 3'd1;
   endfunction

   // A lead byte places its payload bits above the six bits of every continuation to come.
   function automatic void open_sequence(input int len, input logic [7:0] lead_bits);
      logic [31:0] placed;
      placed         = 32'(lead_bits) << (6 * (len - 1));
      open_remaining = 3'(len - 1);
      open_len       = 3'(len);
      gathered_code  = placed[30:0];
   endfunction

   // Advances the predicted state by one byte. Returns 1 when the byte yields a result.
   function automatic bit decode_byte(input logic [7:0] b, input logic mark_last,
                                      output rsp_type res);
      bit          emit;
      logic [31:0] piece;
      emit       = 1'b0;
      res        = '0;
      res.status = ST_OK;
      if (b < ContMin) begin
         // ASCII stands alone and drops whatever was open.
         clear_decode();
         res.code_point = 31'(b);
         res.seq_len    = 3'd1;
         emit           = 1'b1;
      end else if (b < Lead2Min) begin
         if (open_remaining == 0) begin
            // A continuation with nothing open is a stray byte.
            clear_decode();
            res.status = ST_INVALID;
            emit       = 1'b1;
         end else begin
            open_remaining = open_remaining - 3'd1;
            piece          = 32'(b & ContMask) << (6 * open_remaining);
            gathered_code  = gathered_code | piece[30:0];
            if (open_remaining == 0) begin
               res.code_point = gathered_code;
               res.seq_len    = open_len;
               emit           = 1'b1;
               clear_decode();
            end
         end
      end else if (b < Lead3Min) begin
         open_sequence(2, b & Lead2Mask);
      end else if (b < Lead4Min) begin
         open_sequence(3, b & Lead3Mask);
      end else if (b < Lead5Min) begin
         open_sequence(4, b & Lead4Mask);
      end else if (b < Lead6Min) begin
         open_sequence(5, b & Lead5Mask);
      end else if (b < BadMin) begin
         open_sequence(6, b & Lead6Mask);
      end else begin
         clear_decode();
         res.status = ST_INVALID;
         emit       = 1'b1;
      end
      // The last byte of a buffer closes it; an open sequence with no other result is truncated.
      if (mark_last) begin
         if (!emit && open_remaining != 0) begin
            res        = '0;
            res.status = ST_TRUNCATED;
            emit       = 1'b1;
         end
         clear_decode();
      end
      return emit;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Byte sender
   // ---------------------------------------------------------------------------------------

   // Offers one byte beat and waits for it to be taken. Valid is left high so that a
   // following call continues back to back; drain_results and the random idle gaps lower it.
   task automatic send_byte(input logic [7:0] b, input logic mark_last);
      rsp_type want;
      if (req_idle_en && $urandom_range(0, 9) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.in_byte   <= b;
      req_chan.last_byte <= mark_last;
      do @(posedge clock); while (!req_chan.ready);
      if (decode_byte(b, mark_last, want)) expected_results.push_back(want);
      bytes_sent++;
   endtask

   // Sends the first 'count' bytes of a random character of 'len' bytes, marking the last
   // one sent as the end of the buffer when asked. A count below len leaves it unfinished.
   task automatic send_sequence(input int len, input int count, input bit mark_last);
      logic [7:0] lead;
      case (len)
         1:       lead = 8'($urandom_range(0, 127));
         2:       lead = Lead2Min | (8'($urandom) & Lead2Mask);
         3:       lead = Lead3Min | (8'($urandom) & Lead3Mask);
         4:       lead = Lead4Min | (8'($urandom) & Lead4Mask);
         5:       lead = Lead5Min | (8'($urandom) & Lead5Mask);
         default: lead = Lead6Min | (8'($urandom) & Lead6Mask);
      endcase
      send_byte(lead, mark_last && count == 1);
      for (int i = 2; i <= count; i++) begin
         send_byte(ContMin | (8'($urandom) & ContMask), mark_last && i == count);
      end
   endtask

   // Stops offering bytes and waits until every predicted result has come back, then waits on
   // through a tail so that a spurious late beat would still be seen by the checker.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------------
   // Result receiver and checker
   // ---------------------------------------------------------------------------------------

   // Ready drops for random bursts, and for a long hold-off when a test asks for one.
   always @(posedge clock) begin : result_sink
      int stall_left;
      if (hold_off_cycles > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_off_cycles--;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else if (rsp_stall_en && $urandom_range(0, 9) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left = $urandom_range(1, 16) - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Every result beat is matched against the oldest prediction, field by field.
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_results.size() == 0) begin
            fail_count++;
            if (fail_count <= MaxReports) begin
               $display("[%0t] unexpected result beat: cp=%h len=%0d st=%0d", $time,
                        rsp_chan.code_point, rsp_chan.seq_len, rsp_chan.status);
            end
         end else begin
            want = expected_results.pop_front();
            if (rsp_chan.code_point !== want.code_point || rsp_chan.seq_len !== want.seq_len ||
                rsp_chan.status !== want.status) begin
               fail_count++;
               if (fail_count <= MaxReports) begin
                  $display("[%0t] result mismatch: expected cp=%h len=%0d st=%0d, got cp=%h len=%0d st=%0d",
                           $time, want.code_point, want.seq_len, want.status,
                           rsp_chan.code_point, rsp_chan.seq_len, rsp_chan.status);
               end
            end
         end
      end
   end

   // A run that stops moving beats for too long has hung.
   always @(posedge clock) begin : watchdog
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Field extremes, every sequence length, and each special case of the decoder.
   task automatic test_directed();
      // The smallest ASCII byte, then the largest code point a six-byte form can carry.
      send_byte(8'h00, 1'b0);
      send_byte(8'hFD, 1'b0);
      repeat (5) send_byte(8'hBF, 1'b0);
      // A two-byte form with all payload bits zero, then complete three, four and five-byte forms.
      send_byte(8'hC0, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hF4, 1'b0);
      send_byte(8'h8F, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hF8, 1'b0);
      send_byte(8'h88, 1'b0);
      repeat (3) send_byte(8'h80, 1'b0);
      // A stray continuation byte, and one of the two bytes that never appear in UTF-8.
      send_byte(8'h80, 1'b0);
      send_byte(8'hFE, 1'b0);
      // An invalid byte marked last must not also report a truncated sequence.
      send_byte(8'hE2, 1'b0);
      send_byte(8'hFF, 1'b1);
      // A new lead byte inside a sequence drops the open one and restarts.
      send_byte(8'hE2, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'hA9, 1'b0);
      // An ASCII byte inside a sequence drops it as well.
      send_byte(8'hE2, 1'b0);
      send_byte(8'h41, 1'b0);
      // The buffer ends in the middle of a character.
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b1);
      // The largest ASCII byte closes a buffer normally.
      send_byte(8'h7F, 1'b1);
      drain_results();
   endtask

   // Mostly well-formed text with random content, mixed with cut-off sequences, stray
   // continuations, invalid bytes and raw noise. Idling is switched per stretch.
   task automatic test_random_text(input int chunks, input int chunk_bytes);
      int stop_at;
      int kind;
      int len;
      for (int c = 0; c < chunks; c++) begin
         req_idle_en  = ($urandom_range(0, 3) != 0);
         rsp_stall_en = ($urandom_range(0, 3) != 0);
         stop_at      = bytes_sent + chunk_bytes;
         while (bytes_sent < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
               len = $urandom_range(1, 6);
               send_sequence(len, len, $urandom_range(0, 9) == 0);
            end else if (kind < 82) begin
               len = $urandom_range(2, 6);
               send_sequence(len, $urandom_range(1, len - 1), $urandom_range(0, 1) == 1);
            end else if (kind < 92) begin
               if ($urandom_range(0, 2) == 0) begin
                  send_byte(BadMin | 8'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
               end else begin
                  send_byte(ContMin | (8'($urandom) & ContMask), $urandom_range(0, 9) == 0);
               end
            end else begin
               send_byte(8'($urandom), $urandom_range(0, 19) == 0);
            end
         end
         drain_results();
      end
   endtask

   // The receiver holds ready low for a long stretch while ASCII beats keep coming, so the
   // output register and then the input stage fill and the block must stall its input.
   task automatic test_backpressure();
      req_idle_en     = 1'b0;
      rsp_stall_en    = 1'b0;
      hold_off_cycles = HoldCycles;
      repeat (40) send_byte(8'($urandom_range(0, 127)), $urandom_range(0, 7) == 0);
      drain_results();
   endtask

   // The closing stretch runs at full rate on both sides.
   task automatic test_full_rate(input int count);
      int stop_at;
      int len;
      req_idle_en  = 1'b0;
      rsp_stall_en = 1'b0;
      stop_at      = bytes_sent + count;
      while (bytes_sent < stop_at) begin
         len = $urandom_range(1, 6);
         if ($urandom_range(0, 4) == 0) begin
            send_sequence(len, $urandom_range(1, len), $urandom_range(0, 1) == 1);
         end else begin
            send_sequence(len, len, $urandom_range(0, 9) == 0);
         end
      end
      drain_results();
   endtask

   // ---------------------------------------------------------------------------------------
   // Sequence of the run
   // ---------------------------------------------------------------------------------------

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.in_byte   = '0;
      req_chan.last_byte = 1'b0;
      rsp_chan.ready     = 1'b0;
      fail_count         = 0;
      bytes_sent         = 0;
      quiet_cycles       = 0;
      hold_off_cycles    = 0;
      req_idle_en        = 1'b1;
      rsp_stall_en       = 1'b1;
      clear_decode();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_text(6, 110);
      test_backpressure();
      test_random_text(1, 60);
      test_full_rate(150);

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
